/* rtl/brs_pkg.sv */
package brs_pkg;

  localparam int unsigned MtN = 624;
  localparam int unsigned MtM = 397;
  localparam int unsigned PermMax = 64;
  localparam int unsigned PosW = 10;
  localparam int unsigned PermIdxW = 6;
  localparam int unsigned SizeW = 7;
  localparam int unsigned BoundW = 31;

  localparam logic [31:0] MtMatrix = 32'h9908_B0DF;
  localparam logic [31:0] MtInitMul = 32'd1812433253;
  localparam logic [31:0] MtSeedReset = 32'd5489;
  localparam logic [PosW-1:0] MtLast = PosW'(MtN - 1);
  localparam logic [PosW-1:0] MtEnd = PosW'(MtN);
  localparam logic [PosW-1:0] MtWrapAt = PosW'(MtN - MtM);

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdShuffle = 1'b1;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* rtl/bounded_random_and_shuffle.sv */
// Bounded draw: after accept the FSM runs S_DRAW, S_FETCH, S_TEMPER and the
// 32-step divider, after regenerating the 624-word state once all words are used;
// each word by S_GEN_RD0..S_GEN_RD2 and S_GEN_WR through one memory read port.
// Shuffle of n items: a fill pass, then per swap a draw and S_SW0..S_SW3, then
// S_EMIT_RD and S_EMIT_OUT per emitted item; one item is worked on at a time.
// During init after reset or a seed write no item or seed write is accepted.
module bounded_random_and_shuffle (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,       // seed
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // max_value[30:0], perm_size[37:31], zero
  input  logic        s_axis_tuser_i,   // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // value[30:0], zero
  output logic        m_axis_tlast_o
);
  import brs_pkg::*;

  typedef enum logic [4:0] {
    S_INIT_SEED, S_INIT_MUL, S_INIT_WR, S_IDLE, S_DRAW,
    S_GEN_RD0, S_GEN_RD1, S_GEN_RD2, S_GEN_WR, S_FETCH, S_TEMPER, S_DIV,
    S_FILL, S_SW0, S_SW1, S_SW2, S_SW3, S_EMIT_RD, S_EMIT_OUT
  } state_e;

  state_e                state_q;
  logic [31:0]           seed_q, prev_q, prod_q, a_q, b_q, word_q, rem_q;
  logic [PosW-1:0]       k_q, pos_q;
  logic                  cmd_q;
  logic [BoundW-1:0]     bound_q, div_m_q;
  logic [SizeW-1:0]      n_q, e_q;
  logic [PermIdxW-1:0]   i_q, j_q, tj_q;
  logic [4:0]            cnt_q;
  logic                  out_valid_q, out_last_q;
  logic [BoundW-1:0]     out_data_q;

  logic [31:0]           mt_mem [MtN];
  logic [31:0]           mt_rdata_q;
  logic                  mt_we;
  logic [PosW-1:0]       mt_waddr, mt_raddr;
  logic [31:0]           mt_wdata;

  logic [PermIdxW-1:0]   perm_mem [PermMax];
  logic [PermIdxW-1:0]   p_rdata_q;
  logic                  p_we;
  logic [PermIdxW-1:0]   p_waddr, p_raddr, p_wdata;

  logic [PosW-1:0]       k_next, k_far;
  logic [31:0]           y_mix, regen_val, init_val;
  logic [32:0]           div_sh;
  logic                  div_ge;
  logic [SizeW-1:0]      ps_sat;
  logic                  in_acc;

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};
  assign m_axis_tlast_o  = out_last_q;

  assign k_next    = (k_q == MtLast) ? '0 : k_q + PosW'(1);
  assign k_far     = (k_q < MtWrapAt) ? k_q + PosW'(MtM) : k_q - MtWrapAt;
  assign y_mix     = {a_q[31], b_q[30:0]};
  assign regen_val = mt_rdata_q ^ (y_mix >> 1) ^ (y_mix[0] ? MtMatrix : 32'h0);
  assign init_val  = prod_q + {22'h0, k_q};
  assign div_sh    = {rem_q, word_q[31]};
  assign div_ge    = div_sh >= {2'b00, div_m_q};
  assign ps_sat    = (s_axis_tdata_i[37:31] > SizeW'(PermMax)) ? SizeW'(PermMax)
                                                                : s_axis_tdata_i[37:31];

  always_comb begin
    mt_we    = 1'b0;
    mt_waddr = k_q;
    mt_wdata = init_val;
    mt_raddr = pos_q;
    p_we     = 1'b0;
    p_waddr  = e_q[PermIdxW-1:0];
    p_wdata  = e_q[PermIdxW-1:0];
    p_raddr  = j_q;
    case (state_q)
      S_INIT_SEED: begin
        mt_we    = 1'b1;
        mt_waddr = '0;
        mt_wdata = seed_q;
      end
      S_INIT_WR: mt_we = 1'b1;
      S_GEN_RD0: mt_raddr = k_q;
      S_GEN_RD1: mt_raddr = k_next;
      S_GEN_RD2: mt_raddr = k_far;
      S_GEN_WR: begin
        mt_we    = 1'b1;
        mt_wdata = regen_val;
      end
      S_FILL: p_we = 1'b1;
      S_SW1: p_raddr = i_q;
      S_SW2: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = p_rdata_q;
      end
      S_SW3: begin
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = tj_q;
      end
      S_EMIT_RD: p_raddr = e_q[PermIdxW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mt_we) begin
      mt_mem[mt_waddr] <= mt_wdata;
    end
    mt_rdata_q <= mt_mem[mt_raddr];
    if (p_we) begin
      perm_mem[p_waddr] <= p_wdata;
    end
    p_rdata_q <= perm_mem[p_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT_SEED;
      seed_q      <= MtSeedReset;
      pos_q       <= MtEnd;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT_SEED: begin
          prev_q  <= seed_q;
          k_q     <= PosW'(1);
          state_q <= S_INIT_MUL;
        end
        S_INIT_MUL: begin
          prod_q  <= (prev_q ^ (prev_q >> 30)) * MtInitMul;
          state_q <= S_INIT_WR;
        end
        S_INIT_WR: begin
          prev_q <= init_val;
          if (k_q == MtLast) begin
            pos_q   <= MtEnd;
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + PosW'(1);
            state_q <= S_INIT_MUL;
          end
        end
        S_IDLE: begin
          if (cfg_valid_i) begin
            seed_q  <= cfg_data_i;
            state_q <= S_INIT_SEED;
          end else if (in_acc) begin
            cmd_q   <= s_axis_tuser_i;
            bound_q <= s_axis_tdata_i[30:0];
            n_q     <= ps_sat;
            e_q     <= '0;
            if (s_axis_tuser_i == CmdDraw) begin
              state_q <= S_DRAW;
            end else if (ps_sat != '0) begin
              state_q <= S_FILL;
            end
          end
        end
        S_DRAW: begin
          k_q     <= '0;
          state_q <= (pos_q >= MtEnd) ? S_GEN_RD0 : S_FETCH;
        end
        S_GEN_RD0: state_q <= S_GEN_RD1;
        S_GEN_RD1: begin
          a_q     <= mt_rdata_q;
          state_q <= S_GEN_RD2;
        end
        S_GEN_RD2: begin
          b_q     <= mt_rdata_q;
          state_q <= S_GEN_WR;
        end
        S_GEN_WR: begin
          if (k_q == MtLast) begin
            pos_q   <= '0;
            state_q <= S_FETCH;
          end else begin
            k_q     <= k_q + PosW'(1);
            state_q <= S_GEN_RD0;
          end
        end
        S_FETCH: state_q <= S_TEMPER;
        S_TEMPER: begin
          word_q  <= temper(mt_rdata_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          pos_q   <= pos_q + PosW'(1);
          div_m_q <= (cmd_q == CmdShuffle) ? BoundW'(i_q) + BoundW'(1) : bound_q;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= div_ge ? 32'(div_sh - {2'b00, div_m_q}) : div_sh[31:0];
          word_q <= {word_q[30:0], 1'b0};
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            if (cmd_q == CmdDraw) begin
              out_valid_q <= 1'b1;
              out_last_q  <= 1'b1;
              out_data_q  <= (bound_q == '0) ? '0 :
                             (div_ge ? BoundW'(div_sh - {2'b00, div_m_q})
                                     : div_sh[BoundW-1:0]);
              state_q     <= S_IDLE;
            end else begin
              j_q     <= div_ge ? PermIdxW'(div_sh - {2'b00, div_m_q})
                                : div_sh[PermIdxW-1:0];
              state_q <= S_SW0;
            end
          end
        end
        S_FILL: begin
          if (e_q == n_q - SizeW'(1)) begin
            i_q     <= e_q[PermIdxW-1:0];
            e_q     <= '0;
            state_q <= (e_q == '0) ? S_EMIT_RD : S_DRAW;
          end else begin
            e_q <= e_q + SizeW'(1);
          end
        end
        S_SW0: state_q <= S_SW1;
        S_SW1: begin
          tj_q    <= p_rdata_q;
          state_q <= S_SW2;
        end
        S_SW2: state_q <= S_SW3;
        S_SW3: begin
          i_q     <= i_q - PermIdxW'(1);
          state_q <= (i_q == PermIdxW'(1)) ? S_EMIT_RD : S_DRAW;
        end
        S_EMIT_RD: begin
          if (!out_valid_q) begin
            state_q <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          out_valid_q <= 1'b1;
          out_data_q  <= BoundW'(p_rdata_q);
          out_last_q  <= (e_q == n_q - SizeW'(1));
          if (e_q == n_q - SizeW'(1)) begin
            state_q <= S_IDLE;
          end else begin
            e_q     <= e_q + SizeW'(1);
            state_q <= S_EMIT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MtEnd) else $error("twister position out of range");

  a_fetch_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> pos_q < MtEnd) else $error("fetch without fresh words");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_q && !cfg_valid_i)
    else $error("item accepted while result pending");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == 5'd31 && cmd_q == CmdDraw |=> out_valid_q && out_last_q)
    else $error("draw did not produce a final result");

endmodule

/* dv/bounded_random_and_shuffle_test.sv */
`timescale 1ns / 100ps

module bounded_random_and_shuffle_test;
  import brs_pkg::*;

  typedef struct packed {
    logic [30:0] value;
    logic        last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;   // max_value[30:0], perm_size[37:31], zero
  logic        s_axis_tuser_i;   // cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // value[30:0], zero
  logic        m_axis_tlast_o;

  bounded_random_and_shuffle uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  localparam int unsigned CycleLimit = 8000000;
  localparam int unsigned SettleCycles = 200;

  logic [31:0] twister_words [MtN];
  int unsigned twister_pos;
  logic [5:0]  perm_order [PermMax];
  result_t     expected_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          idling_on;
  int unsigned receiver_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void twister_seed(input logic [31:0] s);
    logic [31:0] p;
    twister_words[0] = s;
    for (int k = 1; k < MtN; k++) begin
      p = twister_words[k-1];
      twister_words[k] = (p ^ (p >> 30)) * MtInitMul + 32'(k);
    end
    twister_pos = MtN;
  endfunction

  function automatic logic [31:0] twister_next();
    logic [31:0] y;
    logic [31:0] v;
    if (twister_pos >= MtN) begin
      for (int k = 0; k < MtN; k++) begin
        y = {twister_words[k][31], twister_words[(k + 1) % MtN][30:0]};
        v = twister_words[(k + MtM) % MtN] ^ (y >> 1);
        if (y[0]) v = v ^ MtMatrix;
        twister_words[k] = v;
      end
      twister_pos = 0;
    end
    y = twister_words[twister_pos];
    twister_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void predict_results(input logic cmd, input logic [30:0] bound,
                                          input logic [6:0] size);
    logic [31:0] w;
    int unsigned n;
    int unsigned j;
    logic [5:0]  t;
    result_t     r;
    if (cmd == CmdDraw) begin
      w = twister_next();
      r.value = (bound == 0) ? 31'd0 : 31'(w % {1'b0, bound});
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    n = (size > PermMax) ? PermMax : size;
    for (int i = 0; i < n; i++) perm_order[i] = 6'(i);
    for (int i = int'(n) - 1; i > 0; i--) begin
      j = twister_next() % (i + 1);
      t = perm_order[j];
      perm_order[j] = perm_order[i];
      perm_order[i] = t;
    end
    for (int i = 0; i < n; i++) begin
      r.value = 31'(perm_order[i]);
      r.last = (i + 1 == n);
      expected_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input logic cmd, input logic [30:0] bound, input logic [6:0] size);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {2'b00, size, bound};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_results(cmd, bound, size);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] s);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    twister_seed(s);
  endtask

  task automatic send_random_item();
    logic [30:0] bound;
    logic [6:0]  size;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    bound = (pick < 3) ? 31'($urandom_range(0, 20)) : 31'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 7) size = 7'($urandom_range(0, 8));
    else if (pick < 9) size = 7'($urandom_range(9, 20));
    else size = 7'($urandom_range(0, 127));
    send_item(1'($urandom_range(0, 1)), bound, size);
  endtask

  task automatic test_reset_seed();
    send_item(CmdDraw, 31'd1, 7'd0);
    send_item(CmdDraw, 31'd0, 7'h7F);
    send_item(CmdDraw, 31'h7FFF_FFFF, 7'd0);
    send_item(CmdDraw, 31'd2, 7'd0);
    send_item(CmdDraw, 31'h5555_5555, 7'd0);
    send_item(CmdShuffle, 31'h7FFF_FFFF, 7'd0);
    send_item(CmdShuffle, 31'd0, 7'd1);
    send_item(CmdShuffle, 31'd0, 7'd2);
    send_item(CmdShuffle, 31'd0, 7'd64);
    send_item(CmdShuffle, 31'd0, 7'd65);
    send_item(CmdShuffle, 31'd0, 7'd127);
    send_item(CmdDraw, 31'd7, 7'd0);
  endtask

  task automatic test_seed_extremes();
    write_seed(32'd0);
    send_item(CmdDraw, 31'h7FFF_FFFF, 7'd0);
    send_item(CmdShuffle, 31'd0, 7'd5);
    write_seed(32'hFFFF_FFFF);
    send_item(CmdDraw, 31'h7FFF_FFFF, 7'd0);
    send_item(CmdShuffle, 31'd0, 7'd5);
    write_seed($urandom());
    send_item(CmdDraw, 31'd1000, 7'd0);
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    receiver_hold = 3000;
    repeat (4) send_item(CmdShuffle, 31'($urandom()), 7'd64);
    wait_drained();
  endtask

  task automatic test_random_items();
    for (int phase = 0; phase < 4; phase++) begin
      write_seed((phase == 0) ? MtSeedReset : $urandom());
      if (phase == 3) idling_on = 1'b0;
      repeat (90) send_random_item();
    end
    wait_drained();
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result value", m_axis_tdata_o[30:0], -1);
        end else begin
          if (m_axis_tdata_o[30:0] !== expected_results[0].value)
            report_mismatch("value", m_axis_tdata_o[30:0], expected_results[0].value);
          if (m_axis_tlast_o !== expected_results[0].last)
            report_mismatch("last", m_axis_tlast_o, expected_results[0].last);
          void'(expected_results.pop_front());
        end
      end
      if (receiver_hold > 0) begin
        receiver_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 2);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    idling_on = 1'b1;
    receiver_hold = 0;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= 1'b0;
    m_axis_tready_i <= 1'b0;
    twister_seed(MtSeedReset);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_seed();
    test_seed_extremes();
    test_output_backpressure();
    test_random_items();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/brs_pkg.sv
rtl/bounded_random_and_shuffle.sv
dv/bounded_random_and_shuffle_test.sv
